// ===== hdl/mdts_pkg.sv =====
// shared types, constants and codes of the misaligned dma transfer splitter
package mdts_pkg;

    // sizing
    localparam int MAX_BURST   = 512;
    localparam int TEMP_BYTES  = 128;
    localparam int QUEUE_DEPTH = 8;

    // derived burst limits
    localparam int BURST_RAW    = (MAX_BURST / 4) * 4;
    localparam int BURST_LIM    = (BURST_RAW < 4) ? 4 : BURST_RAW;
    localparam int TEMP_MIN     = (TEMP_BYTES < BURST_LIM) ? TEMP_BYTES : BURST_LIM;
    localparam int TEMP_CAP_RAW = ((TEMP_MIN - 4) / 4) * 4;
    localparam int TEMP_CAP     = (TEMP_CAP_RAW < 4) ? 4 : TEMP_CAP_RAW;

    // queue addressing
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int QSW = $clog2(2 * QUEUE_DEPTH) + 1;

    // field widths
    localparam int BCW = 10;

    // input actions
    localparam logic [1:0] ACT_START_1D = 2'd0;
    localparam logic [1:0] ACT_START_2D = 2'd1;
    localparam logic [1:0] ACT_DONE     = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_DIRECT     = 3'd0;
    localparam logic [2:0] KIND_TEMP_BURST = 3'd1;
    localparam logic [2:0] KIND_TEMP_COPY  = 3'd2;
    localparam logic [2:0] KIND_COMPLETE   = 3'd3;
    localparam logic [2:0] KIND_FULL       = 3'd4;
    localparam logic [2:0] KIND_UNSUP      = 3'd5;

    // command ops from front to back
    localparam logic [1:0] OP_REPLY = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_DONE  = 2'd2;

    typedef struct packed {
        logic        is_2d;
        logic        wr;
        logic [31:0] loc;
        logic [31:0] ram;
        logic [31:0] size;
        logic [31:0] len;
        logic [31:0] stride;
    } t_req;

    localparam int REQ_W = $bits(t_req);

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] kind;
        t_req       req;
    } t_cmd;

endpackage

// ===== hdl/mdts_ram.sv =====
// generic single write port ram with registered read
module mdts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mdts_front.sv =====
// front end: config register, request checks and a two entry command queue
module mdts_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_region_bits,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_action,
    input  logic                i_is_write,
    input  logic [31:0]         i_local_addr,
    input  logic [31:0]         i_ram_addr,
    input  logic [31:0]         i_total_size,
    input  logic [31:0]         i_line_length,
    input  logic signed [31:0]  i_line_stride,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output mdts_pkg::t_cmd      o_cmd
);

    logic [31:0]    r_region;
    mdts_pkg::t_cmd r_fifo [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    logic           accept;
    logic           is_start;
    logic           push;
    logic           pop;
    logic           bad;
    mdts_pkg::t_cmd cmd_in;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_cnt != 2'd2);
    assign accept      = i_valid && o_ready;

    // classify the incoming transfer
    always_comb begin
        is_start          = (i_action == mdts_pkg::ACT_START_1D) ||
                            (i_action == mdts_pkg::ACT_START_2D);
        cmd_in.req.is_2d  = (i_action == mdts_pkg::ACT_START_2D);
        cmd_in.req.wr     = i_is_write;
        cmd_in.req.loc    = i_local_addr;
        cmd_in.req.ram    = i_ram_addr | r_region;
        cmd_in.req.size   = i_total_size;
        cmd_in.req.len    = i_line_length;
        cmd_in.req.stride = 32'(i_line_stride);
        bad = i_is_write && ((i_local_addr[1:0] != 2'd0) || cmd_in.req.ram[0] ||
                             (i_total_size[1:0] != 2'd0) ||
                             (cmd_in.req.is_2d && ((i_line_length[1:0] != 2'd0) ||
                                                   i_line_stride[0])));
        if (cmd_in.req.is_2d && (i_line_length == 32'd0) && (i_total_size != 32'd0)) begin
            bad = 1'b1;
        end
        cmd_in.kind = mdts_pkg::KIND_COMPLETE;
        priority if (!is_start) begin
            cmd_in.op = mdts_pkg::OP_DONE;
        end else if (bad) begin
            cmd_in.op   = mdts_pkg::OP_REPLY;
            cmd_in.kind = mdts_pkg::KIND_UNSUP;
        end else if (i_total_size == 32'd0) begin
            cmd_in.op = mdts_pkg::OP_REPLY;
        end else begin
            cmd_in.op = mdts_pkg::OP_START;
        end
        push = accept && (is_start || (i_action == mdts_pkg::ACT_DONE));
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_fifo[r_rp];
    assign pop         = o_cmd_valid && i_cmd_ready;

    // region register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region <= 32'd0;
        end else if (i_cfg_valid) begin
            r_region <= i_cfg_region_bits;
        end
    end

    // command queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= cmd_in;
        end
    end

    // command queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== hdl/mdts_back.sv =====
// back end: request walker, pending request queue and result register
module mdts_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  mdts_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [2:0]      o_kind,
    output logic            o_dir_write,
    output logic [31:0]     o_out_local_addr,
    output logic [31:0]     o_out_ram_addr,
    output logic [9:0]      o_byte_count,
    output logic            o_temp_offset,
    output logic            o_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    localparam logic [31:0] BLIM = 32'(mdts_pkg::BURST_LIM);
    localparam logic [31:0] TCAP = 32'(mdts_pkg::TEMP_CAP);

    logic [1:0]              r_state, n_state;
    logic                    r_active, n_active;
    logic                    r_emul, n_emul;
    logic                    r_cur_write, n_cur_write;
    logic [31:0]             r_cur_local, n_cur_local;
    logic [31:0]             r_cur_ram, n_cur_ram;
    logic [31:0]             r_line_left, n_line_left;
    logic [31:0]             r_total_left, n_total_left;
    logic [31:0]             r_line_len, n_line_len;
    logic [31:0]             r_stride, n_stride;
    logic                    r_copy_pend, n_copy_pend;
    logic [31:0]             r_burst_left, n_burst_left;
    logic [mdts_pkg::QAW-1:0] r_head, n_head;
    logic [mdts_pkg::QCW-1:0] r_count, n_count;

    // result register
    logic        r_ov;
    logic [2:0]  r_kind;
    logic        r_dir;
    logic [31:0] r_oloc;
    logic [31:0] r_oram;
    logic [9:0]  r_cnt;
    logic        r_off;
    logic        r_last;

    logic        slot_free;
    logic        emit;
    logic [2:0]  e_kind;
    logic        e_dir;
    logic [31:0] e_loc;
    logic [31:0] e_ram;
    logic [31:0] e_cnt;
    logic        e_off;
    logic        e_last;

    logic        do_load;
    mdts_pkg::t_req ld;
    logic        q_we;
    logic        q_re;
    logic [mdts_pkg::QSW-1:0] wsum;
    logic [mdts_pkg::QAW-1:0] waddr;
    logic [mdts_pkg::REQ_W-1:0] q_rdata;

    logic [1:0]  pro;
    logic [31:0] pro32;
    logic [31:0] sa_full;
    logic [31:0] sa_temp;
    logic [31:0] chunk_src;
    logic [31:0] chunk;
    logic [31:0] adv;
    logic        do_adv;
    logic [31:0] tot_next;

    assign slot_free   = !r_ov || i_ready;
    assign o_cmd_ready = (r_state == ST_IDLE) && slot_free;

    // pending request store
    assign wsum  = mdts_pkg::QSW'(r_head) + mdts_pkg::QSW'(r_count);
    assign waddr = (wsum >= mdts_pkg::QSW'(mdts_pkg::QUEUE_DEPTH)) ?
                   mdts_pkg::QAW'(wsum - mdts_pkg::QSW'(mdts_pkg::QUEUE_DEPTH)) :
                   mdts_pkg::QAW'(wsum);

    mdts_ram #(
        .WIDTH(mdts_pkg::REQ_W),
        .DEPTH(mdts_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_we   (q_we),
        .i_waddr(waddr),
        .i_wdata(i_cmd.req),
        .i_re   (q_re),
        .i_raddr(r_head),
        .o_rdata(q_rdata)
    );

    // split arithmetic for the current line
    always_comb begin
        pro       = (r_line_left < 32'd4) ? r_line_left[1:0] : (2'd0 - r_cur_local[1:0]);
        pro32     = {30'd0, pro};
        sa_full   = {r_line_left[31:2], 2'b00};
        sa_temp   = (sa_full > TCAP) ? TCAP : sa_full;
        chunk_src = (r_state == ST_IDLE) ? r_burst_left : sa_full;
        chunk     = (chunk_src > BLIM) ? BLIM : chunk_src;
        tot_next  = r_total_left - r_line_len;
    end

    // walker step
    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_emul       = r_emul;
        n_cur_write  = r_cur_write;
        n_cur_local  = r_cur_local;
        n_cur_ram    = r_cur_ram;
        n_line_left  = r_line_left;
        n_total_left = r_total_left;
        n_line_len   = r_line_len;
        n_stride     = r_stride;
        n_copy_pend  = r_copy_pend;
        n_burst_left = r_burst_left;
        n_head       = r_head;
        n_count      = r_count;
        emit    = 1'b0;
        e_kind  = mdts_pkg::KIND_COMPLETE;
        e_dir   = 1'b0;
        e_loc   = 32'd0;
        e_ram   = 32'd0;
        e_cnt   = 32'd0;
        e_off   = 1'b0;
        e_last  = 1'b1;
        do_load = 1'b0;
        ld      = i_cmd.req;
        q_we    = 1'b0;
        q_re    = 1'b0;
        adv     = 32'd0;
        do_adv  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && slot_free) begin
                    unique case (i_cmd.op)
                        mdts_pkg::OP_REPLY: begin
                            emit   = 1'b1;
                            e_kind = i_cmd.kind;
                            e_dir  = i_cmd.req.wr;
                        end
                        mdts_pkg::OP_START: begin
                            if (r_active) begin
                                if (r_count == mdts_pkg::QCW'(mdts_pkg::QUEUE_DEPTH)) begin
                                    emit   = 1'b1;
                                    e_kind = mdts_pkg::KIND_FULL;
                                    e_dir  = i_cmd.req.wr;
                                end else begin
                                    q_we    = 1'b1;
                                    n_count = r_count + mdts_pkg::QCW'(1);
                                end
                            end else begin
                                do_load = 1'b1;
                            end
                        end
                        mdts_pkg::OP_DONE: begin
                            if (r_active) begin
                                if (r_burst_left != 32'd0) begin
                                    emit   = 1'b1;
                                    e_kind = mdts_pkg::KIND_DIRECT;
                                    e_dir  = r_cur_write;
                                    e_loc  = r_cur_local;
                                    e_ram  = r_cur_ram;
                                    e_cnt  = chunk;
                                    adv    = chunk;
                                    do_adv = 1'b1;
                                    n_burst_left = r_burst_left - chunk;
                                end else begin
                                    n_state = ST_RUN;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (slot_free) begin
                    priority if (pro != 2'd0) begin
                        if (!r_copy_pend) begin
                            emit        = 1'b1;
                            e_kind      = mdts_pkg::KIND_TEMP_BURST;
                            e_ram       = {r_cur_ram[31:1], 1'b0};
                            e_cnt       = 32'd4;
                            n_copy_pend = 1'b1;
                            n_state     = ST_IDLE;
                        end else begin
                            emit        = 1'b1;
                            e_kind      = mdts_pkg::KIND_TEMP_COPY;
                            e_loc       = r_cur_local;
                            e_cnt       = pro32;
                            e_off       = r_cur_ram[0];
                            e_last      = 1'b0;
                            n_copy_pend = 1'b0;
                            adv         = pro32;
                            do_adv      = 1'b1;
                        end
                    end else if (r_line_left != 32'd0) begin
                        if (!r_cur_ram[0]) begin
                            emit   = 1'b1;
                            e_kind = mdts_pkg::KIND_DIRECT;
                            e_dir  = r_cur_write;
                            e_loc  = r_cur_local;
                            e_ram  = r_cur_ram;
                            e_cnt  = chunk;
                            adv    = chunk;
                            do_adv = 1'b1;
                            n_burst_left = sa_full - chunk;
                            n_state      = ST_IDLE;
                        end else if (!r_copy_pend) begin
                            emit        = 1'b1;
                            e_kind      = mdts_pkg::KIND_TEMP_BURST;
                            e_ram       = {r_cur_ram[31:1], 1'b0};
                            e_cnt       = sa_temp + 32'd4;
                            n_copy_pend = 1'b1;
                            n_state     = ST_IDLE;
                        end else begin
                            emit        = 1'b1;
                            e_kind      = mdts_pkg::KIND_TEMP_COPY;
                            e_loc       = r_cur_local;
                            e_cnt       = sa_temp;
                            e_off       = 1'b1;
                            e_last      = 1'b0;
                            n_copy_pend = 1'b0;
                            adv         = sa_temp;
                            do_adv      = 1'b1;
                        end
                    end else if (r_emul && (r_total_left > r_line_len)) begin
                        // next 2d line
                        n_total_left = tot_next;
                        n_cur_ram    = r_cur_ram - r_line_len + r_stride;
                        n_line_left  = (tot_next > r_line_len) ? r_line_len : tot_next;
                    end else begin
                        // request complete, pull the next waiting one
                        emit         = 1'b1;
                        e_kind       = mdts_pkg::KIND_COMPLETE;
                        e_dir        = r_cur_write;
                        n_total_left = 32'd0;
                        n_active     = 1'b0;
                        if (r_count != '0) begin
                            e_last  = 1'b0;
                            q_re    = 1'b1;
                            n_count = r_count - mdts_pkg::QCW'(1);
                            n_head  = (r_head == mdts_pkg::QAW'(mdts_pkg::QUEUE_DEPTH - 1)) ?
                                      '0 : r_head + mdts_pkg::QAW'(1);
                            n_state = ST_LOAD;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_LOAD: begin
                do_load = 1'b1;
                ld      = q_rdata;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (do_adv) begin
            n_cur_local = r_cur_local + adv;
            n_cur_ram   = r_cur_ram + adv;
            n_line_left = r_line_left - adv;
        end
        if (do_load) begin
            n_cur_write  = ld.wr;
            n_cur_local  = ld.loc;
            n_cur_ram    = ld.ram;
            n_emul       = ld.is_2d;
            n_line_len   = ld.len;
            n_stride     = ld.stride;
            n_total_left = ld.is_2d ? ld.size : 32'd0;
            n_line_left  = (ld.is_2d && (ld.size > ld.len)) ? ld.len : ld.size;
            n_copy_pend  = 1'b0;
            n_burst_left = 32'd0;
            n_active     = 1'b1;
            n_state      = ST_RUN;
        end
    end

    // walker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_active     <= 1'b0;
            r_emul       <= 1'b0;
            r_cur_write  <= 1'b0;
            r_cur_local  <= 32'd0;
            r_cur_ram    <= 32'd0;
            r_line_left  <= 32'd0;
            r_total_left <= 32'd0;
            r_line_len   <= 32'd0;
            r_stride     <= 32'd0;
            r_copy_pend  <= 1'b0;
            r_burst_left <= 32'd0;
            r_head       <= '0;
            r_count      <= '0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_emul       <= n_emul;
            r_cur_write  <= n_cur_write;
            r_cur_local  <= n_cur_local;
            r_cur_ram    <= n_cur_ram;
            r_line_left  <= n_line_left;
            r_total_left <= n_total_left;
            r_line_len   <= n_line_len;
            r_stride     <= n_stride;
            r_copy_pend  <= n_copy_pend;
            r_burst_left <= n_burst_left;
            r_head       <= n_head;
            r_count      <= n_count;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (slot_free) begin
            r_ov <= emit;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (slot_free && emit) begin
            r_kind <= e_kind;
            r_dir  <= e_dir;
            r_oloc <= e_loc;
            r_oram <= e_ram;
            r_cnt  <= e_cnt[mdts_pkg::BCW-1:0];
            r_off  <= e_off;
            r_last <= e_last;
        end
    end

    assign o_valid          = r_ov;
    assign o_kind           = r_kind;
    assign o_dir_write      = r_dir;
    assign o_out_local_addr = r_oloc;
    assign o_out_ram_addr   = r_oram;
    assign o_byte_count     = r_cnt;
    assign o_temp_offset    = r_off;
    assign o_last           = r_last;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mdts_pkg::QCW'(mdts_pkg::QUEUE_DEPTH))
        else $error("pending queue count overflow");
    a_run_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> r_active)
        else $error("walker running without an active request");
    a_burst_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_burst_left != 32'd0) |-> (r_active && !r_copy_pend))
        else $error("burst remainder outside a direct request");
    a_load_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |=> (r_state == ST_RUN) && r_active)
        else $error("queued request not loaded");

endmodule

// ===== hdl/misaligned_dma_transfer_splitter_top.sv =====
// A start on an idle block passes the command queue, the walker load and the result
// register; a reply or a burst done with a direct remainder passes only the command queue
// and the result register. The walker gives one further result per step, with a step of
// its own per 2d line and a ram read in the load state per queued request. Throughput:
// one transfer per cycle into the 2 entry command queue while it has room; the walker
// takes a new command only when idle with a free result slot. Reset: synchronous active
// low, clears walker state, queue counts and region register.
module misaligned_dma_transfer_splitter_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_region_bits,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic               i_is_write,
    input  logic [31:0]        i_local_addr,
    input  logic [31:0]        i_ram_addr,
    input  logic [31:0]        i_total_size,
    input  logic [31:0]        i_line_length,
    input  logic signed [31:0] i_line_stride,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_kind,
    output logic               o_dir_write,
    output logic [31:0]        o_out_local_addr,
    output logic [31:0]        o_out_ram_addr,
    output logic [9:0]         o_byte_count,
    output logic               o_temp_offset,
    output logic               o_last
);

    logic           cmd_valid;
    logic           cmd_ready;
    mdts_pkg::t_cmd cmd;

    // request checks and command queue
    mdts_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_region_bits(i_cfg_region_bits),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_is_write       (i_is_write),
        .i_local_addr     (i_local_addr),
        .i_ram_addr       (i_ram_addr),
        .i_total_size     (i_total_size),
        .i_line_length    (i_line_length),
        .i_line_stride    (i_line_stride),
        .o_cmd_valid      (cmd_valid),
        .i_cmd_ready      (cmd_ready),
        .o_cmd            (cmd)
    );

    // request walker
    mdts_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .o_cmd_ready     (cmd_ready),
        .i_cmd           (cmd),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_dir_write     (o_dir_write),
        .o_out_local_addr(o_out_local_addr),
        .o_out_ram_addr  (o_out_ram_addr),
        .o_byte_count    (o_byte_count),
        .o_temp_offset   (o_temp_offset),
        .o_last          (o_last)
    );

endmodule
